>>> sv/dtf_pkg.sv
package dtf_pkg;

	// fixed field widths
	localparam int COORD_W       = 8;
	localparam int SIZE_W        = 9;
	localparam int DEPTH_FIELD_W = 16;
	localparam int COLOR_W       = 32;

	// default sizes
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int FRAC_BITS_DEF  = 14;

	localparam logic [COLOR_W-1:0] CLEAR_COLOR = 32'h0000_00FF;

	// configuration register indexes
	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		REQ_DRAW  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef struct packed {
		req_t kind;
		logic oor;
	} req_info_t;

endpackage

>>> sv/dtf_mem.sv
module dtf_mem #(
	parameter int AW     = 16,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**AW];
	logic [DATA_W-1:0] rd_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

>>> sv/dtf_req_dec.sv
module dtf_req_dec #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 14,
	parameter int AW         = 16,
	parameter int DW         = 16
) (
	input  logic [dtf_pkg::SIZE_W-1:0]               width_in_use,
	input  logic [dtf_pkg::SIZE_W-1:0]               height_in_use,
	input  logic [1:0]                               req_type,
	input  logic [dtf_pkg::COORD_W-1:0]              pos_x,
	input  logic [dtf_pkg::COORD_W-1:0]              pos_y,
	input  logic signed [dtf_pkg::DEPTH_FIELD_W-1:0] frag_depth,
	output dtf_pkg::req_info_t                       info,
	output logic [AW-1:0]                            addr,
	output logic [AW:0]                              clr_count,
	output logic signed [DW-1:0]                     depth_sat,
	output logic signed [DW-1:0]                     depth_floor
);
	import dtf_pkg::*;

	logic [SIZE_W-1:0]    eff_w;
	logic [SIZE_W-1:0]    eff_h;
	logic [16:0]          lin_addr;
	logic [17:0]          area;
	logic signed [DW-1:0] d_ext;
	logic signed [DW-1:0] one;
	req_t                 kind;

	// sizes in use saturate at the store dimensions
	assign eff_w = (32'(width_in_use) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : width_in_use;
	assign eff_h = (32'(height_in_use) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : height_in_use;

	assign lin_addr  = 17'(pos_y) * 17'(eff_w) + 17'(pos_x);
	assign addr      = AW'(lin_addr);
	assign area      = 18'(eff_w) * 18'(eff_h);
	assign clr_count = (AW+1)'(area);

	assign kind = req_t'(req_type);

	always_comb begin
		info.kind = kind;
		info.oor  = 1'b0;
		if (kind == REQ_DRAW || kind == REQ_READ) begin
			info.oor = (SIZE_W'(pos_x) >= eff_w) || (SIZE_W'(pos_y) >= eff_h);
		end
	end

	// saturate to [-1, 1]
	assign one         = DW'(1) <<< FRAC_BITS;
	assign depth_floor = -one;
	assign d_ext       = DW'(frag_depth);

	always_comb begin
		if (d_ext > one) begin
			depth_sat = one;
		end else if (d_ext < depth_floor) begin
			depth_sat = depth_floor;
		end else begin
			depth_sat = d_ext;
		end
	end

endmodule

>>> sv/depth_tested_framebuffer.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | req_type, pos_x, pos_y, frag_depth, frag_color
// out      | out_valid / out_ready| was_written, out_of_range, read_color, read_depth
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// draw, read and no-op words can be taken back to back: the read of the memories,
// then the depth test and write-back as the word leaves stage 1, bypassed when
// the next word hits the entry being written in the same cycle
// clear holds the input until its walk is done, one entry of each memory per cycle
// reset acts only on control and the size registers; memory contents are undefined
// until the first clear, and no clearing pass runs after reset
// a stalled output holds the word in flight and input stalls behind it
module depth_tested_framebuffer #(
	parameter int MAX_WIDTH  = dtf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dtf_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [1:0]                               req_type,
	input  logic [dtf_pkg::COORD_W-1:0]              pos_x,
	input  logic [dtf_pkg::COORD_W-1:0]              pos_y,
	input  logic signed [dtf_pkg::DEPTH_FIELD_W-1:0] frag_depth,
	input  logic [dtf_pkg::COLOR_W-1:0]              frag_color,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     was_written,
	output logic                                     out_of_range,
	output logic [dtf_pkg::COLOR_W-1:0]              read_color,
	output logic signed [dtf_pkg::DEPTH_FIELD_W-1:0] read_depth,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [0:0]                               cfg_index,
	input  logic [dtf_pkg::SIZE_W-1:0]               cfg_data
);
	import dtf_pkg::*;

	// store geometry and depth word width
	localparam int STORE_N = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = (STORE_N > 1) ? $clog2(STORE_N) : 1;
	localparam int DW      = (FRAC_BITS + 2 > DEPTH_FIELD_W) ? FRAC_BITS + 2 : DEPTH_FIELD_W;

	// size registers
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;

	// decoded request
	req_info_t            dec_info;
	logic [AW-1:0]        dec_addr;
	logic [AW:0]          dec_clr_count;
	logic signed [DW-1:0] dec_depth;
	logic signed [DW-1:0] depth_floor;

	// stage 1: memory read in flight / depth test
	logic                 s1_valid_q;
	req_info_t            s1_info;
	logic [AW-1:0]        s1_addr;
	logic signed [DW-1:0] s1_depth;
	logic [COLOR_W-1:0]   s1_color;
	logic                 s1_byp;
	logic [COLOR_W-1:0]   s1_byp_color;
	logic signed [DW-1:0] s1_byp_depth;

	// clear walk
	logic [AW:0] clr_cnt_q;
	logic [AW:0] clr_n_s1;

	// output word
	logic                            out_valid_q;
	logic                            was_written_q;
	logic                            out_of_range_q;
	logic [COLOR_W-1:0]              read_color_q;
	logic signed [DEPTH_FIELD_W-1:0] read_depth_q;

	// memory ports
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [COLOR_W-1:0]   mem_wcolor;
	logic signed [DW-1:0] mem_wdepth;
	logic [COLOR_W-1:0]   cmem_rdata;
	logic [DW-1:0]        dmem_rdata;

	logic                 accept;
	logic                 clr_busy;
	logic                 s1_adv;
	logic                 pass;
	logic                 is_read;
	logic [COLOR_W-1:0]   cur_color;
	logic signed [DW-1:0] cur_depth;

	// configuration: the user must write it only while idle; the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(256);
			height_q <= SIZE_W'(256);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	dtf_req_dec #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.FRAC_BITS (FRAC_BITS),
		.AW        (AW),
		.DW        (DW)
	) u_dec (
		.width_in_use (width_q),
		.height_in_use(height_q),
		.req_type     (req_type),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.frag_depth   (frag_depth),
		.info         (dec_info),
		.addr         (dec_addr),
		.clr_count    (dec_clr_count),
		.depth_sat    (dec_depth),
		.depth_floor  (depth_floor)
	);

	// stage 1 holds a clear until its walk is done
	assign clr_busy = s1_valid_q && (s1_info.kind == REQ_CLEAR) && (clr_cnt_q != clr_n_s1);
	assign s1_adv   = s1_valid_q && !clr_busy && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;

	// read data, with the write of the same edge bypassed in
	assign cur_color = s1_byp ? s1_byp_color : cmem_rdata;
	assign cur_depth = s1_byp ? s1_byp_depth : $signed(dmem_rdata);

	// equal depth overwrites
	assign pass    = (s1_info.kind == REQ_DRAW) && !s1_info.oor && (s1_depth >= cur_depth);
	assign is_read = (s1_info.kind == REQ_READ) && !s1_info.oor;

	// write port: clear walk or a passing draw as it leaves stage 1
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = s1_addr;
		mem_wcolor = s1_color;
		mem_wdepth = s1_depth;
		if (clr_busy) begin
			mem_we     = 1'b1;
			mem_waddr  = clr_cnt_q[AW-1:0];
			mem_wcolor = CLEAR_COLOR;
			mem_wdepth = depth_floor;
		end else if (s1_adv && pass) begin
			mem_we = 1'b1;
		end
	end

	dtf_mem #(
		.AW    (AW),
		.DATA_W(COLOR_W)
	) u_color_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wcolor),
		.re   (accept),
		.raddr(dec_addr),
		.rdata(cmem_rdata)
	);

	dtf_mem #(
		.AW    (AW),
		.DATA_W(DW)
	) u_depth_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdepth),
		.re   (accept),
		.raddr(dec_addr),
		.rdata(dmem_rdata)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			clr_cnt_q  <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				clr_cnt_q  <= '0;
			end else begin
				if (s1_adv) begin
					s1_valid_q <= 1'b0;
				end
				if (clr_busy) begin
					clr_cnt_q <= clr_cnt_q + (AW+1)'(1);
				end
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_info      <= dec_info;
			s1_addr      <= dec_addr;
			s1_depth     <= dec_depth;
			s1_color     <= frag_color;
			clr_n_s1     <= dec_clr_count;
			// a draw writing this entry at the same edge as the read
			s1_byp       <= mem_we && (mem_waddr == dec_addr);
			s1_byp_color <= mem_wcolor;
			s1_byp_depth <= mem_wdepth;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			was_written_q  <= pass;
			out_of_range_q <= s1_info.oor;
			read_color_q   <= is_read ? cur_color : '0;
			read_depth_q   <= is_read ? $signed(cur_depth[DEPTH_FIELD_W-1:0]) : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign was_written  = was_written_q;
	assign out_of_range = out_of_range_q;
	assign read_color   = read_color_q;
	assign read_depth   = read_depth_q;

endmodule
